@@ rtl/lhm_pkg.sv @@
// Shared constants for the link health monitor: level width, lifecycle,
// health, status, action and register index codes, and packed field widths.
// No dependencies; every other file of the block refers to it by scoped name.
package lhm_pkg;

	// Width of the degraded counter's saturation limit (8 to 32).
	localparam int LEVEL_WIDTH = 16;

	// Field widths taken from the interface definition.
	localparam int CNT_W   = 16;
	localparam int HARD_W  = 8;
	localparam int TICK_W  = 32;
	localparam int CODE_W  = 3;
	localparam int STAT_W  = 2;
	localparam int RRES_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 40;

	// Largest level the counter may hold regardless of degraded_max.
	localparam logic [CNT_W-1:0] LEVEL_CAP_LIMIT = (LEVEL_WIDTH >= CNT_W) ?
		{CNT_W{1'b1}} : CNT_W'((64'd1 << LEVEL_WIDTH) - 64'd1);

	localparam logic [HARD_W-1:0] HARD_MAX = {HARD_W{1'b1}};

	// Lifecycle states.
	localparam logic [CODE_W-1:0] LIFE_READY      = 3'd0;
	localparam logic [CODE_W-1:0] LIFE_RUNNING    = 3'd1;
	localparam logic [CODE_W-1:0] LIFE_DEGRADED   = 3'd2;
	localparam logic [CODE_W-1:0] LIFE_OFFLINE    = 3'd3;
	localparam logic [CODE_W-1:0] LIFE_RECOVERING = 3'd4;

	// Health codes, in rising severity.
	localparam logic [CODE_W-1:0] HLTH_OK       = 3'd0;
	localparam logic [CODE_W-1:0] HLTH_CRC      = 3'd1;
	localparam logic [CODE_W-1:0] HLTH_FRAMING  = 3'd2;
	localparam logic [CODE_W-1:0] HLTH_OVERRUN  = 3'd3;
	localparam logic [CODE_W-1:0] HLTH_TIMEOUT  = 3'd4;
	localparam logic [CODE_W-1:0] HLTH_HW_FAULT = 3'd5;
	localparam logic [CODE_W-1:0] HLTH_FATAL    = 3'd6;

	// Status answers.
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_WAIT   = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_OK = 2'd2;

	// Item kinds and recovery outcomes.
	localparam logic ACT_CHECK    = 1'b0;
	localparam logic ACT_RECOVERY = 1'b1;

	localparam logic [RRES_W-1:0] RR_SUCCESS   = 2'd0;
	localparam logic [RRES_W-1:0] RR_INIT_FAIL = 2'd1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEGRADED_MAX     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEGRADED_DECAY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEGRADED_HIGH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEGRADED_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HARD_ERROR_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RX_TIMEOUT_TICKS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FATAL_HEALTH_MIN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WARN_HEALTH_MIN  = 3'd7;

endpackage

@@ rtl/link_health_monitor.sv @@
// Link health monitor top level: input register, single-pass check and
// recovery logic, state registers and output register.
// Depends on lhm_pkg for codes and widths.
//
// Each transfer on the slave stream is one item. s_tuser selects its kind:
// a check tick or the outcome of a recovery attempt. Every item yields
// exactly one result transfer on the master stream, carrying status,
// health code, lifecycle state, degraded level, hard error count and a
// re-arm request flag.
// The item is held in the input register and is decided into the output
// register once that is empty or its result is taken. Throughput is one
// item per cycle while the receiver does not stall; the state update is a
// single pass of compare-and-add logic, so each item sees the state its
// predecessor left without any wait.
// When the receiver stalls, the finished result holds in the output
// register and one more item may sit in the input register; s_tready drops
// only once both are full, and rises again in the cycle the result is taken.
// Reset clears the lifecycle to ready, the health to ok, both counters to
// zero and the configuration registers to their defaults, and empties both
// stages. Configuration writes must only be issued while no item is in flight.
module link_health_monitor (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_wr_en,
	input  logic [lhm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lhm_pkg::CFG_DATA_W-1:0]  cfg_wdata,

	input  logic                            s_tvalid,
	output logic                            s_tready,
	// recovery_result[1:0], err_dma[2], err_overrun[3], err_line[4],
	// pkt_crc_err[5], pkt_frame_err[6], rearm_failed[7], now_tick[39:8],
	// last_rx_time[71:40], error_weight[87:72]
	input  logic [lhm_pkg::IN_DATA_W-1:0]   s_tdata,
	// action[0]
	input  logic                            s_tuser,

	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status[1:0], health_code[4:2], life_state[7:5],
	// degraded_level[23:8], hard_errors[31:24], rearm_request[32],
	// zero fill[39:33]
	output logic [lhm_pkg::OUT_DATA_W-1:0]  m_tdata
);

	typedef struct packed {
		logic                           action;
		logic [lhm_pkg::RRES_W-1:0]     rres;
		logic                           e_dma;
		logic                           e_ore;
		logic                           e_line;
		logic                           p_crc;
		logic                           p_frm;
		logic                           rearm_fail;
		logic [lhm_pkg::TICK_W-1:0]     now;
		logic [lhm_pkg::TICK_W-1:0]     last;
		logic [lhm_pkg::CNT_W-1:0]      weight;
	} item_t;

	typedef struct packed {
		logic [lhm_pkg::STAT_W-1:0]     status;
		logic [lhm_pkg::CODE_W-1:0]     health;
		logic [lhm_pkg::CODE_W-1:0]     life;
		logic [lhm_pkg::CNT_W-1:0]      level;
		logic [lhm_pkg::HARD_W-1:0]     hard;
		logic                           rearm;
	} result_t;

	// Configuration registers.
	logic [lhm_pkg::CNT_W-1:0]  deg_max_q, deg_decay_q, deg_high_q, deg_low_q;
	logic [lhm_pkg::HARD_W-1:0] hard_limit_q;
	logic [lhm_pkg::TICK_W-1:0] rx_timeout_q;
	logic [lhm_pkg::CODE_W-1:0] fatal_min_q, warn_min_q;

	// Block state.
	logic [lhm_pkg::CODE_W-1:0] life_q;
	logic [lhm_pkg::CODE_W-1:0] health_q;
	logic [lhm_pkg::CNT_W-1:0]  level_q;
	logic [lhm_pkg::HARD_W-1:0] hard_q;

	// Pipeline.
	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_q;

	logic    advance;
	item_t   item_in;
	result_t res;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign item_in.action     = s_tuser;
	assign item_in.rres       = s_tdata[1:0];
	assign item_in.e_dma      = s_tdata[2];
	assign item_in.e_ore      = s_tdata[3];
	assign item_in.e_line     = s_tdata[4];
	assign item_in.p_crc      = s_tdata[5];
	assign item_in.p_frm      = s_tdata[6];
	assign item_in.rearm_fail = s_tdata[7];
	assign item_in.now        = s_tdata[39:8];
	assign item_in.last       = s_tdata[71:40];
	assign item_in.weight     = s_tdata[87:72];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_max_q    <= 16'd100;
			deg_decay_q  <= 16'd1;
			deg_high_q   <= 16'd40;
			deg_low_q    <= 16'd10;
			hard_limit_q <= 8'd3;
			rx_timeout_q <= 32'd100;
			fatal_min_q  <= lhm_pkg::HLTH_HW_FAULT;
			warn_min_q   <= lhm_pkg::HLTH_CRC;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				lhm_pkg::REG_DEGRADED_MAX:     deg_max_q    <= cfg_wdata[15:0];
				lhm_pkg::REG_DEGRADED_DECAY:   deg_decay_q  <= cfg_wdata[15:0];
				lhm_pkg::REG_DEGRADED_HIGH:    deg_high_q   <= cfg_wdata[15:0];
				lhm_pkg::REG_DEGRADED_LOW:     deg_low_q    <= cfg_wdata[15:0];
				lhm_pkg::REG_HARD_ERROR_LIMIT: hard_limit_q <= cfg_wdata[7:0];
				lhm_pkg::REG_RX_TIMEOUT_TICKS: rx_timeout_q <= cfg_wdata;
				lhm_pkg::REG_FATAL_HEALTH_MIN: fatal_min_q  <= cfg_wdata[2:0];
				lhm_pkg::REG_WARN_HEALTH_MIN:  warn_min_q   <= cfg_wdata[2:0];
			endcase
		end
	end

	// Decision logic: one pass from the current state and the registered
	// item to the next state, which is also the reported result.
	logic [lhm_pkg::CNT_W-1:0]  cap;
	logic [lhm_pkg::HARD_W-1:0] escalated;
	logic [lhm_pkg::CNT_W:0]    level_sum;
	logic [lhm_pkg::TICK_W-1:0] idle_ticks;

	assign cap        = (deg_max_q < lhm_pkg::LEVEL_CAP_LIMIT) ?
		deg_max_q : lhm_pkg::LEVEL_CAP_LIMIT;
	assign escalated  = (hard_limit_q == lhm_pkg::HARD_MAX) ?
		lhm_pkg::HARD_MAX : hard_limit_q + 8'd1;
	assign level_sum  = {1'b0, level_q} + {1'b0, item_s1.weight};
	assign idle_ticks = item_s1.now - item_s1.last;

	always_comb begin
		logic [lhm_pkg::CODE_W-1:0] h;
		logic [lhm_pkg::CODE_W-1:0] life;
		logic [lhm_pkg::CNT_W-1:0]  lvl;
		logic [lhm_pkg::HARD_W-1:0] hard;
		logic                       rearm;
		logic [lhm_pkg::STAT_W-1:0] st;

		h     = lhm_pkg::HLTH_OK;
		life  = life_q;
		lvl   = level_q;
		hard  = hard_q;
		rearm = 1'b0;
		st    = lhm_pkg::ST_OK;

		if (item_s1.action == lhm_pkg::ACT_RECOVERY) begin
			if (item_s1.rres == lhm_pkg::RR_SUCCESS) begin
				life = lhm_pkg::LIFE_READY;
				h    = lhm_pkg::HLTH_OK;
				lvl  = '0;
				hard = '0;
				st   = lhm_pkg::ST_OK;
			end else begin
				// A failed receive restart also drops the counters; a failed
				// port init keeps them.
				if (item_s1.rres != lhm_pkg::RR_INIT_FAIL) begin
					lvl  = '0;
					hard = '0;
				end
				life = lhm_pkg::LIFE_OFFLINE;
				h    = lhm_pkg::HLTH_FATAL;
				st   = lhm_pkg::ST_NOT_OK;
			end
		end else if (life_q == lhm_pkg::LIFE_RECOVERING) begin
			h  = health_q;
			st = lhm_pkg::ST_WAIT;
		end else if (life_q == lhm_pkg::LIFE_OFFLINE) begin
			h  = health_q;
			st = lhm_pkg::ST_NOT_OK;
		end else begin
			// Low-level errors outrank packet errors, which outrank timeout.
			if (item_s1.e_dma) begin
				h    = lhm_pkg::HLTH_HW_FAULT;
				hard = escalated;
			end else if (item_s1.e_ore || item_s1.e_line) begin
				h     = item_s1.e_ore ? lhm_pkg::HLTH_OVERRUN : lhm_pkg::HLTH_FRAMING;
				rearm = 1'b1;
				if (item_s1.rearm_fail) begin
					h    = lhm_pkg::HLTH_HW_FAULT;
					hard = escalated;
				end else if (hard_q != lhm_pkg::HARD_MAX) begin
					hard = hard_q + 8'd1;
				end
			end else if (item_s1.p_crc) begin
				h = lhm_pkg::HLTH_CRC;
			end else if (item_s1.p_frm) begin
				h = lhm_pkg::HLTH_FRAMING;
			end else if (life_q != lhm_pkg::LIFE_READY) begin
				if (idle_ticks > rx_timeout_q)
					h = lhm_pkg::HLTH_TIMEOUT;
				else
					hard = '0;
			end

			// Leaky bucket: fill by weight up to the cap, else drain.
			if (h != lhm_pkg::HLTH_OK)
				lvl = (level_sum > {1'b0, cap}) ? cap : level_sum[lhm_pkg::CNT_W-1:0];
			else
				lvl = (level_q > deg_decay_q) ? level_q - deg_decay_q : '0;

			if (life == lhm_pkg::LIFE_READY &&
				(h != lhm_pkg::HLTH_OK || item_s1.last != '0))
				life = lhm_pkg::LIFE_RUNNING;
			if (life == lhm_pkg::LIFE_DEGRADED && lvl == cap)
				life = lhm_pkg::LIFE_OFFLINE;
			if (life == lhm_pkg::LIFE_RUNNING && lvl >= deg_high_q)
				life = lhm_pkg::LIFE_DEGRADED;
			else if (life == lhm_pkg::LIFE_DEGRADED && lvl <= deg_low_q)
				life = lhm_pkg::LIFE_RUNNING;

			if (h >= fatal_min_q || hard > hard_limit_q) begin
				life = lhm_pkg::LIFE_OFFLINE;
				if (h < lhm_pkg::HLTH_FATAL)
					h = lhm_pkg::HLTH_FATAL;
			end

			if (life == lhm_pkg::LIFE_OFFLINE)
				st = lhm_pkg::ST_NOT_OK;
			else if (h >= warn_min_q)
				st = lhm_pkg::ST_WAIT;
			else
				st = lhm_pkg::ST_OK;
		end

		res.status = st;
		res.health = h;
		res.life   = life;
		res.level  = lvl;
		res.hard   = hard;
		res.rearm  = rearm;
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			life_q      <= lhm_pkg::LIFE_READY;
			health_q    <= lhm_pkg::HLTH_OK;
			level_q     <= '0;
			hard_q      <= '0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (advance) begin
				life_q   <= res.life;
				health_q <= res.health;
				level_q  <= res.level;
				hard_q   <= res.hard;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= item_in;
		if (advance)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.rearm, out_q.hard, out_q.level,
		out_q.life, out_q.health, out_q.status};

	// The recovering state is never entered by this logic.
	a_never_recovering: assert property (@(posedge clk) disable iff (!arst_n)
		life_q != lhm_pkg::LIFE_RECOVERING)
		else $error("lifecycle entered recovering");

	// A re-arm request only accompanies a check that found an error.
	a_rearm_has_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.rearm |-> out_q.health != lhm_pkg::HLTH_OK)
		else $error("re-arm request without an error");

	// Input backpressure only when both stages are full and the result waits.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && out_valid_q && !m_tready)
		else $error("input stalled without a waiting result");

	// An item that moves forward always lands in the output register.
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item did not reach the output");

endmodule
